// ===== rtl/gmi_pkg.sv =====
package gmi_pkg;

  // Fixed field and datapath widths
  localparam int NREG_DIMS = 4;
  localparam int Q_W       = 32;
  localparam int FRAC_W    = 24;
  localparam int FAC_W     = 25;
  localparam int CNT_W     = 7;
  localparam int DEN_W     = 33;
  localparam int DIV_W     = 49;
  localparam int WPROD_W   = Q_W + FAC_W;
  localparam int SUM_W     = 56;

  localparam logic signed [FRAC_W-1:0] FRAC_ONE  = 24'sd65536;
  localparam logic signed [FRAC_W-1:0] FRAC_HALF = 24'sd32768;
  localparam logic signed [FRAC_W-1:0] FRAC_MAX  = 24'sh7FFFFF;
  localparam logic signed [FRAC_W-1:0] FRAC_MIN  = 24'sh800000;
  localparam logic signed [Q_W-1:0]    Q_ONE     = 32'sd65536;
  localparam logic signed [Q_W-1:0]    Q_MAX     = 32'sh7FFFFFFF;
  localparam logic signed [Q_W-1:0]    Q_MIN     = 32'sh80000000;

  // Input transaction modes
  localparam logic [2:0] MODE_BP_WR    = 3'd0;
  localparam logic [2:0] MODE_TBL_WR   = 3'd1;
  localparam logic [2:0] MODE_CLAMP_LO = 3'd2;
  localparam logic [2:0] MODE_CLAMP_HI = 3'd3;
  localparam logic [2:0] MODE_QUERY    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_NUM_DIMS   = 3'd0;
  localparam logic [2:0] CFG_BP_COUNT_0 = 3'd1;
  localparam logic [2:0] CFG_BP_COUNT_1 = 3'd2;
  localparam logic [2:0] CFG_BP_COUNT_2 = 3'd3;
  localparam logic [2:0] CFG_BP_COUNT_3 = 3'd4;
  localparam logic [2:0] CFG_EXTRAP     = 3'd5;
  localparam logic [2:0] CFG_INTERP     = 3'd6;

  // Per-dimension interpolation codes
  localparam logic [1:0] IM_LINEAR  = 2'd0;
  localparam logic [1:0] IM_NEAREST = 2'd1;
  localparam logic [1:0] IM_FLOOR   = 2'd2;
  localparam logic [1:0] IM_CEIL    = 2'd3;

  // Datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_PROD,
    OP_CLAMP,
    OP_RD_LO,
    OP_RD_HI,
    OP_BS_ADDR,
    OP_BS_CMP,
    OP_RD_A,
    OP_RD_B,
    OP_DIV_SETUP,
    OP_DIV,
    OP_DIV_END,
    OP_CW,
    OP_TB_RD,
    OP_TB_MUL,
    OP_TB_ACC,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic ovf;
    logic dim_last;
    logic in_range;
    logic len_zero;
    logic div_last;
    logic corner_last;
    logic out_free;
  } dp_stat_t;

  // Value fits in signed 32 bits
  function automatic logic fits32(input logic signed [SUM_W-1:0] v);
    return (v <= SUM_W'(Q_MAX)) && (v >= SUM_W'(Q_MIN));
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SUM_W'(Q_MAX)) r = Q_MAX;
    else if (v < SUM_W'(Q_MIN)) r = Q_MIN;
    else r = v[Q_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/gmi_ctrl.sv =====
module gmi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gmi_pkg::dp_stat_t stat,
  output gmi_pkg::dp_cmd_t  cmd
);
  import gmi_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE      = 18'h00001,
    ST_PROD      = 18'h00002,
    ST_PCHK      = 18'h00004,
    ST_CLAMP     = 18'h00008,
    ST_RD_LO     = 18'h00010,
    ST_RD_HI     = 18'h00020,
    ST_BS_ADDR   = 18'h00040,
    ST_BS_CMP    = 18'h00080,
    ST_RD_A      = 18'h00100,
    ST_RD_B      = 18'h00200,
    ST_DIV_SETUP = 18'h00400,
    ST_DIV       = 18'h00800,
    ST_DIV_END   = 18'h01000,
    ST_CW        = 18'h02000,
    ST_TB_RD     = 18'h04000,
    ST_TB_MUL    = 18'h08000,
    ST_TB_ACC    = 18'h10000,
    ST_FIN       = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // no transaction is taken while reset is held
  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode
  always_comb begin
    state_nxt  = state_r;
    cmd.accept = accept;
    cmd.op     = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && stat.is_query) state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.op = OP_PROD;
        if (stat.dim_last) state_nxt = ST_PCHK;
      end
      ST_PCHK: begin
        state_nxt = stat.ovf ? ST_FIN : ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = ST_RD_LO;
      end
      ST_RD_LO: begin
        cmd.op    = OP_RD_LO;
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd.op    = OP_RD_HI;
        state_nxt = stat.in_range ? ST_BS_ADDR : ST_RD_A;
      end
      ST_BS_ADDR: begin
        cmd.op    = OP_BS_ADDR;
        state_nxt = stat.len_zero ? ST_RD_A : ST_BS_CMP;
      end
      ST_BS_CMP: begin
        cmd.op    = OP_BS_CMP;
        state_nxt = ST_BS_ADDR;
      end
      ST_RD_A: begin
        cmd.op    = OP_RD_A;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.op    = OP_RD_B;
        state_nxt = ST_DIV_SETUP;
      end
      ST_DIV_SETUP: begin
        cmd.op    = OP_DIV_SETUP;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd.op    = OP_DIV_END;
        state_nxt = stat.dim_last ? ST_CW : ST_CLAMP;
      end
      ST_CW: begin
        cmd.op = OP_CW;
        if (stat.dim_last) state_nxt = ST_TB_RD;
      end
      ST_TB_RD: begin
        cmd.op    = OP_TB_RD;
        state_nxt = ST_TB_MUL;
      end
      ST_TB_MUL: begin
        cmd.op    = OP_TB_MUL;
        state_nxt = ST_TB_ACC;
      end
      ST_TB_ACC: begin
        cmd.op    = OP_TB_ACC;
        state_nxt = stat.corner_last ? ST_FIN : ST_CW;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== rtl/gmi_dp.sv =====
module gmi_dp #(
  parameter int MAX_DIMS        = 4,
  parameter int MAX_BREAKPOINTS = 64,
  parameter int TABLE_DEPTH     = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gmi_pkg::dp_cmd_t    cmd,
  output gmi_pkg::dp_stat_t   stat,
  input  logic [2:0]          in_mode,
  input  logic [1:0]          in_dim_select,
  input  logic [11:0]         in_load_index,
  input  logic signed [31:0]  in_load_value,
  input  logic signed [31:0]  in_coord_0,
  input  logic signed [31:0]  in_coord_1,
  input  logic signed [31:0]  in_coord_2,
  input  logic signed [31:0]  in_coord_3,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_interp_value,
  output logic                out_saturated,
  output logic                out_table_overflow
);
  import gmi_pkg::*;

  localparam int BP_DEPTH = MAX_DIMS * MAX_BREAKPOINTS;
  localparam int BAW      = $clog2(BP_DEPTH);
  localparam int TAW      = $clog2(TABLE_DEPTH);
  localparam int DIW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PW       = $clog2(TABLE_DEPTH + 2);
  localparam int PMW      = PW + CNT_W;
  localparam int DIM_LIM  = (MAX_DIMS < NREG_DIMS) ? MAX_DIMS : NREG_DIMS;
  localparam int DCW      = $clog2(DIV_W);

  // Configuration registers
  logic [2:0]       num_dims_r;
  logic [CNT_W-1:0] bp_cnt_r [NREG_DIMS];
  logic [7:0]       extrap_r, interp_r;

  // Stores
  logic signed [Q_W-1:0] clamp_lo_r [MAX_DIMS];
  logic signed [Q_W-1:0] clamp_hi_r [MAX_DIMS];
  logic signed [Q_W-1:0] bp_mem [BP_DEPTH];
  logic signed [Q_W-1:0] tbl_mem [TABLE_DEPTH];
  logic signed [Q_W-1:0] bp_rdata_r, tbl_rdata_r;
  logic [BAW-1:0]        bp_raddr;

  // Query working registers
  logic signed [Q_W-1:0]    coord_r [NREG_DIMS];
  logic [2:0]               d_r;
  logic [PW-1:0]            prod_r;
  logic                     ovf_r;
  logic signed [Q_W-1:0]    x_r, lo_r, ba_r;
  logic [CNT_W-1:0]         first_r, len_r, a_r;
  logic [CNT_W-1:0]         seg_r [NREG_DIMS];
  logic signed [FRAC_W-1:0] frac_r [NREG_DIMS];
  logic [DIV_W-1:0]         num_r;
  logic [DEN_W-1:0]         rem_r, den_r;
  logic                     neg_r, den_zero_r;
  logic [DCW-1:0]           div_cnt_r;
  logic [4:0]               c_r;
  logic signed [Q_W-1:0]    w_r;
  logic [TAW-1:0]           off_r;
  logic signed [63:0]       term_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     sat_r;
  logic signed [Q_W-1:0]    out_value_r;
  logic                     out_sat_r, out_ovf_r, out_valid_r;

  // Effective register values
  logic [2:0]       n_eff;
  logic [CNT_W-1:0] cnt_eff [NREG_DIMS];
  logic [CNT_W-1:0] cnt_cur;
  logic [1:0]       dsel;
  logic [BAW-1:0]   base;
  logic [1:0]       ex_cur, im_cur;

  always_comb begin
    n_eff = num_dims_r;
    if (num_dims_r < 3'd1) n_eff = 3'd1;
    if (int'(num_dims_r) > DIM_LIM) n_eff = 3'(DIM_LIM);
    for (int i = 0; i < NREG_DIMS; i++) begin
      cnt_eff[i] = bp_cnt_r[i];
      if (bp_cnt_r[i] < CNT_W'(2)) cnt_eff[i] = CNT_W'(2);
      if (int'(bp_cnt_r[i]) > MAX_BREAKPOINTS) cnt_eff[i] = CNT_W'(MAX_BREAKPOINTS);
    end
  end

  assign dsel    = d_r[1:0];
  assign cnt_cur = cnt_eff[dsel];
  assign base    = BAW'(BAW'(d_r) * BAW'(MAX_BREAKPOINTS));
  assign ex_cur  = 2'(extrap_r >> {dsel, 1'b0});
  assign im_cur  = 2'(interp_r >> {dsel, 1'b0});

  // Clamp of the current coordinate, high bound first
  logic signed [Q_W-1:0] coord_cur, x_hi, x_clamped;
  assign coord_cur = coord_r[dsel];
  assign x_hi      = (coord_cur > clamp_hi_r[d_r[DIW-1:0]]) ? clamp_hi_r[d_r[DIW-1:0]]
                                                            : coord_cur;
  assign x_clamped = (x_hi < clamp_lo_r[d_r[DIW-1:0]]) ? clamp_lo_r[d_r[DIW-1:0]] : x_hi;

  // Range test against the end breakpoints
  logic x_below, x_above;
  assign x_below = x_r < lo_r;
  assign x_above = x_r > bp_rdata_r;

  // Binary search step
  logic [CNT_W-1:0] half, mid, a_fin;
  assign half = len_r >> 1;
  assign mid  = first_r + half;
  always_comb begin
    a_fin = first_r;
    if (a_fin > '0) a_fin = a_fin - CNT_W'(1);
    if (a_fin > cnt_cur - CNT_W'(2)) a_fin = a_fin - CNT_W'(1);
  end

  // Breakpoint read address
  always_comb begin
    case (cmd.op)
      OP_RD_LO:   bp_raddr = base + BAW'(cnt_cur - CNT_W'(1));
      OP_BS_ADDR: bp_raddr = base + BAW'(mid);
      OP_RD_A:    bp_raddr = base + BAW'(a_r);
      OP_RD_B:    bp_raddr = base + BAW'(a_r + CNT_W'(1));
      default:    bp_raddr = base;
    endcase
  end

  // Division setup: magnitudes of numerator and denominator
  logic signed [DEN_W-1:0] dx, dd;
  logic [DEN_W-1:0]        dx_mag, dd_mag;
  assign dx     = DEN_W'(x_r) - DEN_W'(ba_r);
  assign dd     = DEN_W'(bp_rdata_r) - DEN_W'(ba_r);
  assign dx_mag = dx[DEN_W-1] ? DEN_W'(-dx) : DEN_W'(dx);
  assign dd_mag = dd[DEN_W-1] ? DEN_W'(-dd) : DEN_W'(dd);

  // Restoring division step
  logic [DEN_W:0] div_sh, div_diff;
  logic           div_ge;
  assign div_sh   = {rem_r, num_r[DIV_W-1]};
  assign div_ge   = div_sh >= {1'b0, den_r};
  assign div_diff = div_sh - {1'b0, den_r};

  // Fraction saturation and interpolation mode
  logic                     fsat;
  logic signed [FRAC_W-1:0] f_lin, f_new;
  logic                     f_sat_flag;
  always_comb begin
    fsat = 1'b0;
    if (den_zero_r) begin
      f_lin = '0;
    end else if (!neg_r && num_r > DIV_W'(FRAC_MAX)) begin
      f_lin = FRAC_MAX;
      fsat  = 1'b1;
    end else if (neg_r && num_r > DIV_W'(24'h800000)) begin
      f_lin = FRAC_MIN;
      fsat  = 1'b1;
    end else begin
      f_lin = neg_r ? -$signed(num_r[FRAC_W-1:0]) : $signed(num_r[FRAC_W-1:0]);
    end
    case (im_cur)
      IM_LINEAR: begin
        f_new      = f_lin;
        f_sat_flag = fsat;
      end
      IM_NEAREST: begin
        f_new      = (f_lin > FRAC_HALF) ? FRAC_ONE : '0;
        f_sat_flag = fsat;
      end
      IM_FLOOR: begin
        f_new      = '0;
        f_sat_flag = 1'b0;
      end
      default: begin
        f_new      = FRAC_ONE;
        f_sat_flag = 1'b0;
      end
    endcase
  end

  // Corner weight and offset step
  logic [2:0]                corner_sh;
  logic                      cbit;
  logic signed [FAC_W-1:0]   fac;
  logic signed [WPROD_W-1:0] wprod, wprod_rnd;
  logic signed [SUM_W-1:0]   w_rnd;
  logic [TAW-1:0]            off_nxt;
  assign corner_sh = n_eff - 3'd1 - d_r;
  assign cbit      = c_r[corner_sh];
  assign fac       = cbit ? FAC_W'(frac_r[dsel]) : FAC_W'(FAC_W'(Q_ONE) - FAC_W'(frac_r[dsel]));
  assign wprod     = WPROD_W'(w_r) * WPROD_W'(fac);
  assign wprod_rnd = wprod + WPROD_W'(32768);
  assign w_rnd     = SUM_W'($signed(wprod_rnd[WPROD_W-1:16]));
  assign off_nxt   = TAW'(off_r * cnt_cur) + TAW'(seg_r[dsel]) + TAW'(cbit);

  // Term rounding
  logic signed [63:0]      term_rnd;
  logic signed [SUM_W-1:0] sum_nxt;
  assign term_rnd = term_r + 64'sd32768;
  assign sum_nxt  = sum_r + SUM_W'($signed(term_rnd[63:16]));

  // Breakpoint count product for the depth check
  logic [PMW-1:0] prod_mul;
  assign prod_mul = PMW'(prod_r) * PMW'(cnt_cur);

  logic [4:0] corner_max;
  assign corner_max = (5'd1 << n_eff) - 5'd1;

  // Status toward the controller
  assign stat.is_query    = (in_mode == MODE_QUERY);
  assign stat.ovf         = ovf_r;
  assign stat.dim_last    = (d_r == n_eff - 3'd1);
  assign stat.in_range    = !x_below && !x_above;
  assign stat.len_zero    = (len_r == '0);
  assign stat.div_last    = (div_cnt_r == DCW'(DIV_W - 1));
  assign stat.corner_last = (c_r == corner_max);
  assign stat.out_free    = !out_valid_r || out_ready;

  logic wr_fire;
  assign wr_fire = cmd.accept;

  // Memories
  always_ff @(posedge clk) begin
    if (wr_fire && in_mode == MODE_BP_WR && int'(in_dim_select) < MAX_DIMS &&
        int'(in_load_index) < MAX_BREAKPOINTS) begin
      bp_mem[BAW'(BAW'(in_dim_select) * BAW'(MAX_BREAKPOINTS) + BAW'(in_load_index))]
        <= in_load_value;
    end
    bp_rdata_r <= bp_mem[bp_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_fire && in_mode == MODE_TBL_WR && int'(in_load_index) < TABLE_DEPTH) begin
      tbl_mem[TAW'(in_load_index)] <= in_load_value;
    end
    tbl_rdata_r <= tbl_mem[off_r];
  end

  // Configuration registers and clamp bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= 3'd1;
      for (int i = 0; i < NREG_DIMS; i++) bp_cnt_r[i] <= CNT_W'(2);
      extrap_r <= '0;
      interp_r <= '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        clamp_lo_r[i] <= Q_MIN;
        clamp_hi_r[i] <= Q_MAX;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_DIMS:   num_dims_r  <= cfg_data[2:0];
          CFG_BP_COUNT_0: bp_cnt_r[0] <= cfg_data[CNT_W-1:0];
          CFG_BP_COUNT_1: bp_cnt_r[1] <= cfg_data[CNT_W-1:0];
          CFG_BP_COUNT_2: bp_cnt_r[2] <= cfg_data[CNT_W-1:0];
          CFG_BP_COUNT_3: bp_cnt_r[3] <= cfg_data[CNT_W-1:0];
          CFG_EXTRAP:     extrap_r    <= cfg_data;
          CFG_INTERP:     interp_r    <= cfg_data;
          default: ;
        endcase
      end
      if (wr_fire && int'(in_dim_select) < MAX_DIMS) begin
        if (in_mode == MODE_CLAMP_LO) clamp_lo_r[DIW'(in_dim_select)] <= in_load_value;
        if (in_mode == MODE_CLAMP_HI) clamp_hi_r[DIW'(in_dim_select)] <= in_load_value;
      end
    end
  end

  // Query sequencing registers
  always_ff @(posedge clk) begin
    if (wr_fire && in_mode == MODE_QUERY) begin
      coord_r[0] <= in_coord_0;
      coord_r[1] <= in_coord_1;
      coord_r[2] <= in_coord_2;
      coord_r[3] <= in_coord_3;
      d_r        <= '0;
      prod_r     <= PW'(1);
      ovf_r      <= 1'b0;
      sat_r      <= 1'b0;
      sum_r      <= '0;
    end
    case (cmd.op)
      OP_PROD: begin
        if (prod_mul > PMW'(TABLE_DEPTH)) begin
          prod_r <= PW'(TABLE_DEPTH + 1);
          ovf_r  <= 1'b1;
        end else begin
          prod_r <= PW'(prod_mul);
        end
        d_r <= stat.dim_last ? 3'd0 : d_r + 3'd1;
      end
      OP_CLAMP: x_r <= x_clamped;
      OP_RD_LO: lo_r <= bp_rdata_r;
      OP_RD_HI: begin
        if (x_below) begin
          a_r <= '0;
          if (!ex_cur[0]) x_r <= lo_r;
        end else if (x_above) begin
          a_r <= cnt_cur - CNT_W'(2);
          if (!ex_cur[1]) x_r <= bp_rdata_r;
        end
        first_r <= '0;
        len_r   <= cnt_cur;
      end
      OP_BS_ADDR: begin
        if (len_r == '0) a_r <= a_fin;
      end
      OP_BS_CMP: begin
        if (bp_rdata_r < x_r) begin
          first_r <= mid + CNT_W'(1);
          len_r   <= len_r - half - CNT_W'(1);
        end else begin
          len_r <= half;
        end
      end
      OP_RD_B: ba_r <= bp_rdata_r;
      OP_DIV_SETUP: begin
        num_r      <= {dx_mag, 16'd0};
        den_r      <= dd_mag;
        rem_r      <= '0;
        neg_r      <= dx[DEN_W-1] ^ dd[DEN_W-1];
        den_zero_r <= (dd_mag == '0);
        div_cnt_r  <= '0;
      end
      OP_DIV: begin
        rem_r     <= div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
        num_r     <= {num_r[DIV_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r + DCW'(1);
      end
      OP_DIV_END: begin
        frac_r[dsel] <= f_new;
        seg_r[dsel]  <= a_r;
        if (f_sat_flag) sat_r <= 1'b1;
        d_r <= stat.dim_last ? 3'd0 : d_r + 3'd1;
        c_r   <= '0;
        w_r   <= Q_ONE;
        off_r <= '0;
      end
      OP_CW: begin
        w_r   <= sat32(w_rnd);
        if (!fits32(w_rnd)) sat_r <= 1'b1;
        off_r <= off_nxt;
        d_r   <= stat.dim_last ? 3'd0 : d_r + 3'd1;
      end
      OP_TB_MUL: term_r <= 64'(tbl_rdata_r) * 64'(w_r);
      OP_TB_ACC: begin
        sum_r <= sum_nxt;
        c_r   <= c_r + 5'd1;
        w_r   <= Q_ONE;
        off_r <= '0;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.op == OP_FIN) begin
      if (ovf_r) begin
        out_value_r <= '0;
        out_sat_r   <= 1'b0;
        out_ovf_r   <= 1'b1;
      end else begin
        out_value_r <= sat32(sum_r);
        out_sat_r   <= sat_r || !fits32(sum_r);
        out_ovf_r   <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_interp_value   = out_value_r;
  assign out_saturated      = out_sat_r;
  assign out_table_overflow = out_ovf_r;

endmodule

// ===== rtl/gridded_multilinear_interpolator_top.sv =====
// Channel   Ports                                            Direction
// in        in_valid/in_ready, in_mode .. in_coord_3         load or query transaction in
// out       out_valid/out_ready, out_interp_value, flags     one result per query
// cfg       cfg_we, cfg_index, cfg_data                      register write, no wait
//
// Load transactions (breakpoint, table, clamp) do not leave the idle state, so
// the next transaction can be accepted directly after. A query runs from acceptance
// to out_valid through the table depth check, then per dimension the clamp, the binary
// search (up to log2(count)+1 steps) and the division, then the corners; a coordinate
// outside the end breakpoints skips the search. The 49-step restoring divider dominates.
// A query that fails the table depth check goes straight to the result.
// Synchronous active-low reset resets control, the configuration registers and clamp
// bounds; the breakpoint and table memories and query working registers are not cleared.
// in_ready is high only between queries; a finished result waits in the
// output register while the next transaction may already be accepted.
module gridded_multilinear_interpolator_top #(
  parameter int MAX_DIMS        = 4,
  parameter int MAX_BREAKPOINTS = 64,
  parameter int TABLE_DEPTH     = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [1:0]         in_dim_select,
  input  logic [11:0]        in_load_index,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_coord_0,
  input  logic signed [31:0] in_coord_1,
  input  logic signed [31:0] in_coord_2,
  input  logic signed [31:0] in_coord_3,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_interp_value,
  output logic               out_saturated,
  output logic               out_table_overflow
);
  import gmi_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  gmi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, search, divider and accumulation
  gmi_dp #(
    .MAX_DIMS        (MAX_DIMS),
    .MAX_BREAKPOINTS (MAX_BREAKPOINTS),
    .TABLE_DEPTH     (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_mode),
    .in_dim_select      (in_dim_select),
    .in_load_index      (in_load_index),
    .in_load_value      (in_load_value),
    .in_coord_0         (in_coord_0),
    .in_coord_1         (in_coord_1),
    .in_coord_2         (in_coord_2),
    .in_coord_3         (in_coord_3),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_interp_value   (out_interp_value),
    .out_saturated      (out_saturated),
    .out_table_overflow (out_table_overflow)
  );

endmodule

// ===== test/gridded_multilinear_interpolator_top_tb.sv =====
module gridded_multilinear_interpolator_top_tb;
  import gmi_pkg::*;

  // per-dimension extrapolation codes
  localparam logic [1:0] EX_CLAMP = 2'd0;
  localparam logic [1:0] EX_BELOW = 2'd1;
  localparam logic [1:0] EX_ABOVE = 2'd2;
  localparam logic [1:0] EX_BOTH  = 2'd3;

  localparam int NBP    = 64;
  localparam int NTBL   = 4096;
  localparam int ITEMS  = 1200;

  typedef struct {
    logic [2:0]  mode;
    logic [1:0]  dim;
    logic [11:0] idx;
    int          val;
    int          coord[4];
  } txn_t;

  typedef struct {
    int val;
    bit sat;
    bit ovf;
  } lookup_t;

  // Lookup predictor plus the queue of lookups still owed by the block
  class interp_scoreboard;
    int bp[4][NBP];
    int tbl[NTBL];
    int clo[4];
    int chi[4];
    logic [2:0] nd;
    logic [6:0] cnt[4];
    logic [7:0] exm;
    logic [7:0] imm;
    lookup_t owed_q[$];

    function void init_state();
      for (int d = 0; d < 4; d++) begin
        clo[d] = Q_MIN;
        chi[d] = Q_MAX;
        cnt[d] = 7'd2;
      end
      nd = 3'd1;
      exm = '0;
      imm = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        CFG_NUM_DIMS:   nd = data[2:0];
        CFG_BP_COUNT_0: cnt[0] = data[6:0];
        CFG_BP_COUNT_1: cnt[1] = data[6:0];
        CFG_BP_COUNT_2: cnt[2] = data[6:0];
        CFG_BP_COUNT_3: cnt[3] = data[6:0];
        CFG_EXTRAP:     exm = data;
        CFG_INTERP:     imm = data;
        default: ;
      endcase
    endfunction

    function int dims_used();
      if (nd < 1) return 1;
      if (nd > 4) return 4;
      return nd;
    endfunction

    function int count_used(int d);
      if (cnt[d] < 2) return 2;
      if (cnt[d] > NBP) return NBP;
      return cnt[d];
    endfunction

    function longint rnd16(longint v);
      return (v + 32768) >>> 16;
    endfunction

    function longint clip32(longint v, inout bit s);
      if (v > longint'(Q_MAX)) begin s = 1'b1; return Q_MAX; end
      if (v < longint'(Q_MIN)) begin s = 1'b1; return Q_MIN; end
      return v;
    endfunction

    function int first_not_below(int d, int cn, int x);
      int first;
      int len;
      int half;
      first = 0;
      len = cn;
      while (len > 0) begin
        half = len / 2;
        if (bp[d][first + half] < x) begin
          first = first + half + 1;
          len = len - half - 1;
        end else begin
          len = half;
        end
      end
      return first;
    endfunction

    // Apply a load, or predict the lookup of a query
    function void note_txn(txn_t t);
      int n;
      int cn;
      int a;
      int x;
      logic [1:0] e;
      logic [1:0] m;
      longint prod;
      longint num;
      longint den;
      longint f;
      longint frac[4];
      int seg[4];
      longint w;
      longint fac;
      longint off;
      longint sum;
      int b;
      bit fsat;
      bit sat;
      lookup_t r;
      case (t.mode)
        MODE_BP_WR:    if (t.idx < NBP) bp[t.dim][t.idx] = t.val;
        MODE_TBL_WR:   tbl[t.idx] = t.val;
        MODE_CLAMP_LO: clo[t.dim] = t.val;
        MODE_CLAMP_HI: chi[t.dim] = t.val;
        MODE_QUERY: begin
          n = dims_used();
          prod = 1;
          for (int d = 0; d < n; d++) prod = prod * count_used(d);
          if (prod > NTBL) begin
            r.val = 0; r.sat = 1'b0; r.ovf = 1'b1;
            owed_q.push_back(r);
            return;
          end
          sat = 1'b0;
          for (int d = 0; d < n; d++) begin
            cn = count_used(d);
            e = exm[2*d +: 2];
            m = imm[2*d +: 2];
            x = t.coord[d];
            if (x > chi[d]) x = chi[d];
            if (x < clo[d]) x = clo[d];
            if (x < bp[d][0]) begin
              a = 0;
              if (e != EX_BELOW && e != EX_BOTH) x = bp[d][0];
            end else if (x > bp[d][cn-1]) begin
              a = cn - 2;
              if (e != EX_ABOVE && e != EX_BOTH) x = bp[d][cn-1];
            end else begin
              a = first_not_below(d, cn, x);
              if (a > 0) a--;
              if (a > cn - 2) a--;
            end
            seg[d] = a;
            num = (longint'(x) - longint'(bp[d][a])) * 65536;
            den = longint'(bp[d][a+1]) - longint'(bp[d][a]);
            f = (den == 0) ? 0 : num / den;
            fsat = 1'b0;
            if (f > 8388607) begin f = 8388607; fsat = 1'b1; end
            if (f < -8388608) begin f = -8388608; fsat = 1'b1; end
            case (m)
              IM_LINEAR:  if (fsat) sat = 1'b1;
              IM_NEAREST: begin
                if (fsat) sat = 1'b1;
                f = (f > 32768) ? 65536 : 0;
              end
              IM_FLOOR:   f = 0;
              default:    f = 65536;
            endcase
            frac[d] = f;
          end
          // weighted sum over all corners of the cell
          sum = 0;
          for (int c = 0; c < (1 << n); c++) begin
            off = 0;
            w = 65536;
            for (int d = 0; d < n; d++) begin
              b = (c >> (n - 1 - d)) & 1;
              fac = b ? frac[d] : 65536 - frac[d];
              off = off * count_used(d) + seg[d] + b;
              w = clip32(rnd16(w * fac), sat);
            end
            if (off < NTBL) sum += rnd16(longint'(tbl[off]) * w);
          end
          sum = clip32(sum, sat);
          r.val = int'(sum); r.sat = sat; r.ovf = 1'b0;
          owed_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Empty string when the lookup matches the oldest one owed
    function string check_lookup(int v, bit s, bit o);
      lookup_t r;
      if (owed_q.size() == 0)
        return $sformatf("unexpected result value=%0d sat=%0d ovf=%0d", v, s, o);
      r = owed_q.pop_front();
      if (r.val != v || r.sat != s || r.ovf != o)
        return $sformatf("got value=%0d sat=%0d ovf=%0d, want value=%0d sat=%0d ovf=%0d",
                         v, s, o, r.val, r.sat, r.ovf);
      return "";
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_mode;
  logic [1:0]         in_dim_select;
  logic [11:0]        in_load_index;
  logic signed [31:0] in_load_value;
  logic signed [31:0] in_coord_0;
  logic signed [31:0] in_coord_1;
  logic signed [31:0] in_coord_2;
  logic signed [31:0] in_coord_3;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [7:0]         cfg_data;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_interp_value;
  logic               out_saturated;
  logic               out_table_overflow;

  interp_scoreboard sb;
  int  n_errors;
  int  n_lookups;
  int  n_sent;
  bit  in_burst;

  gridded_multilinear_interpolator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_dim_select(in_dim_select),
    .in_load_index(in_load_index), .in_load_value(in_load_value),
    .in_coord_0(in_coord_0), .in_coord_1(in_coord_1),
    .in_coord_2(in_coord_2), .in_coord_3(in_coord_3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_interp_value(out_interp_value), .out_saturated(out_saturated),
    .out_table_overflow(out_table_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Check every result transaction
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      msg = sb.check_lookup(out_interp_value, out_saturated, out_table_overflow);
      if (msg != "") report(msg);
      n_lookups++;
    end
  end

  // Result side: random stalls, runs of none, one long hold-off
  initial begin
    int k;
    bit burst;
    bit held;
    burst = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) burst = ~burst;
      k = burst ? 0 : $urandom_range(0, 8);
      if (!held && n_lookups >= 100) begin
        k = 3000;
        held = 1'b1;
      end
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #(4 * 5000000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic txn_t load_txn(logic [2:0] mode, logic [1:0] dim, int idx, int val);
    txn_t t;
    t.mode = mode;
    t.dim = dim;
    t.idx = idx[11:0];
    t.val = val;
    for (int d = 0; d < 4; d++) t.coord[d] = $urandom;
    return t;
  endfunction

  function automatic txn_t query_txn(int c0, int c1, int c2, int c3);
    txn_t t;
    t = load_txn(MODE_QUERY, 2'($urandom), int'($urandom), int'($urandom));
    t.coord[0] = c0; t.coord[1] = c1; t.coord[2] = c2; t.coord[3] = c3;
    return t;
  endfunction

  // One input transaction, then this item's idle gap
  task automatic send(txn_t t);
    int g;
    in_mode <= t.mode;
    in_dim_select <= t.dim;
    in_load_index <= t.idx;
    in_load_value <= t.val;
    in_coord_0 <= t.coord[0];
    in_coord_1 <= t.coord[1];
    in_coord_2 <= t.coord[2];
    in_coord_3 <= t.coord[3];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_txn(t);
    n_sent++;
    if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
    g = in_burst ? 0 : $urandom_range(0, 8);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Wait until every owed lookup has come back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] v[7]);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= v[i];
      @(posedge clk);
      sb.write_reg(i[2:0], v[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int clip_add(int base, longint delta);
    longint s;
    s = longint'(base) + delta;
    if (s > longint'(Q_MAX)) return Q_MAX;
    if (s < longint'(Q_MIN)) return Q_MIN;
    return int'(s);
  endfunction

  // Coordinate that lands at edges, on breakpoints, inside cells or outside
  function automatic int pick_coord(int d);
    int cn;
    int i;
    longint span;
    cn = sb.count_used(d);
    i = $urandom_range(0, cn - 2);
    case ($urandom_range(0, 9))
      0: return int'($urandom);
      1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      2, 3: return sb.bp[d][$urandom_range(0, cn - 1)];
      8: return clip_add(sb.bp[d][0], -longint'($urandom_range(1, 1 << 20)));
      9: return clip_add(sb.bp[d][cn-1], longint'($urandom_range(1, 1 << 20)));
      default: begin
        span = longint'(sb.bp[d][i+1]) - longint'(sb.bp[d][i]);
        if (span <= 0) return sb.bp[d][i];
        return int'(longint'(sb.bp[d][i]) + longint'($urandom) % (span + 1));
      end
    endcase
  endfunction

  // Breakpoints: mostly ascending, sometimes full-range or unsorted
  task automatic load_breakpoints(int d, int cn);
    int style;
    longint v;
    longint step;
    style = $urandom_range(0, 9);
    v = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    for (int i = 0; i < cn; i++) begin
      if (style == 0) begin
        send(load_txn(MODE_BP_WR, 2'(d), i, int'($urandom)));
      end else if (style == 1) begin
        step = (longint'(Q_MAX) - longint'(Q_MIN)) / (cn - 1);
        send(load_txn(MODE_BP_WR, 2'(d), i, int'(longint'(Q_MIN) + i * step)));
      end else begin
        send(load_txn(MODE_BP_WR, 2'(d), i, int'(v)));
        step = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 1 << 17);
        v = v + step;
      end
    end
  endtask

  task automatic load_clamps();
    int lo;
    int hi;
    for (int d = 0; d < 4; d++) begin
      case ($urandom_range(0, 3))
        0: begin lo = pick_coord(d); hi = pick_coord(d); end
        1: begin lo = int'($urandom); hi = int'($urandom); end
        default: begin lo = Q_MIN; hi = Q_MAX; end
      endcase
      send(load_txn(MODE_CLAMP_LO, 2'(d), int'($urandom), lo));
      send(load_txn(MODE_CLAMP_HI, 2'(d), int'($urandom), hi));
    end
  endtask

  // Ignored modes, ignored breakpoint writes and stray table writes
  function automatic txn_t noise_txn();
    case ($urandom_range(0, 2))
      0: return load_txn(3'($urandom_range(5, 7)), 2'($urandom), int'($urandom),
                         int'($urandom));
      1: return load_txn(MODE_BP_WR, 2'($urandom), $urandom_range(NBP, 4095),
                         int'($urandom));
      default: return load_txn(MODE_TBL_WR, 2'd0, $urandom_range(0, 4095), int'($urandom));
    endcase
  endfunction

  task automatic random_phase();
    logic [7:0] v[7];
    int n;
    int cap;
    int prod;
    int nq;
    int c[4];
    n = $urandom_range(1, 4);
    cap = (n == 1) ? 64 : (n == 2) ? 10 : (n == 3) ? 4 : 3;
    v[CFG_NUM_DIMS] = 8'(n);
    if ($urandom_range(0, 7) == 0)
      v[CFG_NUM_DIMS] = (n == 1) ? 8'd0 : (n == 4) ? 8'd7 : 8'(n);
    for (int d = 0; d < 4; d++) begin
      v[CFG_BP_COUNT_0 + d] = 8'($urandom_range(2, cap));
      if (n == 1 && d == 0 && $urandom_range(0, 5) == 0)
        v[CFG_BP_COUNT_0] = $urandom_range(0, 1) ? 8'd127 : 8'($urandom_range(0, 1));
      if (d >= n) v[CFG_BP_COUNT_0 + d] = 8'($urandom);
    end
    v[CFG_EXTRAP] = 8'($urandom);
    v[CFG_INTERP] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    set_config(v);
    prod = 1;
    for (int d = 0; d < n; d++) begin
      load_breakpoints(d, sb.count_used(d));
      prod = prod * sb.count_used(d);
    end
    load_clamps();
    for (int i = 0; i < prod; i++)
      send(load_txn(MODE_TBL_WR, 2'd0, i,
                    ($urandom_range(0, 4) == 0) ? int'($urandom)
                                                : int'($urandom_range(0, 1 << 22)) - (1 << 21)));
    nq = $urandom_range(30, 70);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(0, 7) == 0) send(noise_txn());
      for (int d = 0; d < 4; d++) c[d] = (d < n) ? pick_coord(d) : int'($urandom);
      send(query_txn(c[0], c[1], c[2], c[3]));
    end
    settle();
  endtask

  initial begin
    logic [7:0] v[7];
    sb = new;
    sb.init_state();
    n_errors = 0;
    n_lookups = 0;
    n_sent = 0;
    in_burst = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_QUERY;
    in_dim_select = '0;
    in_load_index = '0;
    in_load_value = '0;
    in_coord_0 = '0;
    in_coord_1 = '0;
    in_coord_2 = '0;
    in_coord_3 = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_NUM_DIMS;
    cfg_data = '0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero dims and count one act as minimum, both-side extrapolation,
    // extreme table values, ignored writes and modes
    v = '{8'd0, 8'd1, 8'd2, 8'd2, 8'd2, 8'hFF, 8'd0};
    set_config(v);
    send(load_txn(MODE_BP_WR, 2'd0, 0, -65536));
    send(load_txn(MODE_BP_WR, 2'd0, 1, 65536));
    send(load_txn(MODE_TBL_WR, 2'd0, 0, Q_MAX));
    send(load_txn(MODE_TBL_WR, 2'd0, 1, Q_MIN));
    send(load_txn(MODE_BP_WR, 2'd3, 4095, 0));
    send(load_txn(MODE_TBL_WR, 2'd0, 4095, -1));
    send(load_txn(3'd5, 2'd1, 0, 0));
    send(load_txn(3'd6, 2'd2, 0, 0));
    send(load_txn(3'd7, 2'd3, 0, 0));
    send(query_txn(0, 0, 0, 0));
    send(query_txn(Q_MIN, 0, 0, 0));
    send(query_txn(Q_MAX, 0, 0, 0));
    send(query_txn(65536, 0, 0, 0));
    send(load_txn(MODE_CLAMP_HI, 2'd0, 0, -131072));
    send(load_txn(MODE_CLAMP_LO, 2'd0, 0, 131072));
    send(query_txn(Q_MAX, 0, 0, 0));
    send(load_txn(MODE_CLAMP_LO, 2'd0, 0, Q_MIN));
    send(load_txn(MODE_CLAMP_HI, 2'd0, 0, Q_MAX));
    settle();

    // Directed: table overflow, dims above four and an oversize count
    v = '{8'd7, 8'd127, 8'd64, 8'd2, 8'd2, 8'h00, 8'hFF};
    set_config(v);
    send(query_txn(int'($urandom), int'($urandom), int'($urandom), int'($urandom)));
    send(query_txn(Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    settle();

    while (n_sent < ITEMS) random_phase();

    settle();
    repeat (600) @(posedge clk);
    if (n_errors == 0 && sb.owed_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gmi_pkg.sv
rtl/gmi_ctrl.sv
rtl/gmi_dp.sv
rtl/gridded_multilinear_interpolator_top.sv
test/gridded_multilinear_interpolator_top_tb.sv
